@@ design/uvs_pkg.sv @@
package uvs_pkg;

  // Geometry limits and fixed point
  localparam int MAX_DIVISIONS    = 256;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int ANGLE_BITS       = 16;

  localparam int DEPTH_BITS   = $clog2(SINE_TABLE_DEPTH);
  localparam int IDX_W        = DEPTH_BITS + 1;
  localparam int ADDR_SUM_W   = ANGLE_BITS - 2 + DEPTH_BITS + 1;
  localparam int QUARTER_TURN = 1 << (ANGLE_BITS - 2);
  localparam int HALF_QUARTER = QUARTER_TURN / 2;

  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam logic [15:0] NORM_POS_UP = 16'h7FFF;
  localparam logic [15:0] NORM_NEG_DN = 16'h8000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Register map
  typedef enum logic [2:0] {
    REG_STACK_COUNT = 3'd0,
    REG_SLICE_COUNT = 3'd1,
    REG_RADIUS      = 3'd2,
    REG_LAT_STEP    = 3'd3,
    REG_LON_STEP    = 3'd4,
    REG_S_STEP      = 3'd5,
    REG_T_STEP      = 3'd6
  } cfg_reg_t;

  localparam logic [8:0]  RST_STACK_COUNT = 9'd16;
  localparam logic [8:0]  RST_SLICE_COUNT = 9'd32;
  localparam logic [15:0] RST_RADIUS      = 16'd256;
  localparam logic [15:0] RST_LAT_STEP    = 16'd2048;
  localparam logic [15:0] RST_LON_STEP    = 16'd2048;
  localparam logic [16:0] RST_S_STEP      = 17'd2048;
  localparam logic [15:0] RST_T_STEP      = 16'd4096;

  typedef logic [ANGLE_BITS-1:0] angle_t;

  typedef struct packed {
    logic [8:0]  stack_count;
    logic [8:0]  slice_count;
    logic [15:0] radius;
    logic [15:0] lat_step;
    logic [15:0] lon_step;
    logic [16:0] s_step;
    logic [15:0] t_step;
  } cfg_t;

  // One vertex request from the sequencer
  typedef struct packed {
    angle_t      phi;
    angle_t      theta;
    logic [16:0] s;
    logic [16:0] t;
    logic        pole;
    logic        bottom;
    logic        kind;
    logic        first;
    logic        last;
  } job_t;

  typedef struct packed {
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [16:0] pos_z;
    logic [15:0] norm_x;
    logic [15:0] norm_y;
    logic [15:0] norm_z;
    logic [16:0] tex_s;
    logic [16:0] tex_t;
    logic        prim_kind;
    logic        prim_first;
    logic        mesh_last;
  } vertex_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             neg;
  } rom_addr_t;

  typedef logic [15:0] sine_rom_t [0:SINE_TABLE_DEPTH];

  // Quarter-wave sine in Q1.15 from a Q2.30 Taylor series, odd terms to x^15
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 6;   sum = sum - term;
      term = ((term * x2) >> 30) / 20;  sum = sum + term;
      term = ((term * x2) >> 30) / 42;  sum = sum - term;
      term = ((term * x2) >> 30) / 72;  sum = sum + term;
      term = ((term * x2) >> 30) / 110; sum = sum - term;
      term = ((term * x2) >> 30) / 156; sum = sum + term;
      term = ((term * x2) >> 30) / 210; sum = sum - term;
      rom[k] = 16'((sum + 64'd16384) >> 15);
    end
    return rom;
  endfunction

  // Table address and sign for sin(a)
  function automatic rom_addr_t sine_addr(input angle_t a);
    logic [1:0]            quad;
    logic [ANGLE_BITS-3:0] p;
    logic [ADDR_SUM_W-1:0] sum;
    logic [IDX_W-1:0]      idx;
    rom_addr_t             r;
    quad = a[ANGLE_BITS-1 -: 2];
    p    = a[ANGLE_BITS-3:0];
    sum  = ADDR_SUM_W'(p) * ADDR_SUM_W'(SINE_TABLE_DEPTH) + ADDR_SUM_W'(HALF_QUARTER);
    idx  = sum[ANGLE_BITS-2 +: IDX_W];
    if (idx > IDX_W'(SINE_TABLE_DEPTH)) idx = IDX_W'(SINE_TABLE_DEPTH);
    if (quad[0]) idx = IDX_W'(SINE_TABLE_DEPTH) - idx;
    r.idx = idx;
    r.neg = quad[1];
    return r;
  endfunction

  function automatic rom_addr_t cos_addr(input angle_t a);
    return sine_addr(a + angle_t'(QUARTER_TURN));
  endfunction

  // Magnitude product, Q1.15 scale, round half up (sign applied outside)
  function automatic logic [15:0] mul_round(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] p;
    p = 32'(a) * 32'(b) + 32'd16384;
    return p[30:15];
  endfunction

  function automatic logic [16:0] to_s17(input logic [15:0] mag, input logic neg);
    return neg ? (17'd0 - {1'b0, mag}) : {1'b0, mag};
  endfunction

  // Q1.15 normal with saturation of +1.0
  function automatic logic [15:0] norm_sat(input logic [15:0] mag, input logic neg);
    logic [16:0] v;
    v = to_s17(mag, neg);
    if (!neg && mag[15]) return NORM_POS_UP;
    return v[15:0];
  endfunction

endpackage

@@ design/uv_sphere_vertex_generator_top.sv @@
// Path: from input accept to out_tvalid an item passes the queue write, the table read,
//   the first products, then the final product and output register.
// Throughput: one vertex per cycle sustained; the back pipeline stalls as a whole only
//   when the output register is full and not taken; the 4-entry queue absorbs the front.
// Reset: rst_n synchronous, active low; registers return to their default values,
//   the sequencer goes back to the top pole, queue and pipeline are emptied.
module uv_sphere_vertex_generator_top import uvs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [0] restart, [7:1] zero
  // vertex stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // pos_x, pos_y, pos_z (17b each), norm_x, norm_y,
                                   // norm_z (16b each), tex_s, tex_t (17b each), zero pad
  output logic [1:0]   out_tuser,  // [0] prim_kind, [1] prim_first
  output logic         out_tlast,  // mesh_last
  // register writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [16:0]  cfg_data
);

  cfg_t    cfg_r;
  job_t    front_job, head_job;
  logic    take, q_full, q_not_empty, q_pop;
  vertex_t vtx;

  // Register file: always ready, writes land on the next edge.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stack_count <= RST_STACK_COUNT;
      cfg_r.slice_count <= RST_SLICE_COUNT;
      cfg_r.radius      <= RST_RADIUS;
      cfg_r.lat_step    <= RST_LAT_STEP;
      cfg_r.lon_step    <= RST_LON_STEP;
      cfg_r.s_step      <= RST_S_STEP;
      cfg_r.t_step      <= RST_T_STEP;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_STACK_COUNT: cfg_r.stack_count <= cfg_data[8:0];
        REG_SLICE_COUNT: cfg_r.slice_count <= cfg_data[8:0];
        REG_RADIUS:      cfg_r.radius      <= cfg_data[15:0];
        REG_LAT_STEP:    cfg_r.lat_step    <= cfg_data[15:0];
        REG_LON_STEP:    cfg_r.lon_step    <= cfg_data[15:0];
        REG_S_STEP:      cfg_r.s_step      <= cfg_data;
        REG_T_STEP:      cfg_r.t_step      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Front: walks the mesh order, one job per accepted item.
  assign in_tready = !q_full;
  assign take      = in_tvalid && in_tready;

  uvs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .take    (take),
    .restart (in_tdata[0]),
    .job     (front_job)
  );

  // Decouples the sequencer from output backpressure.
  uvs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_job  (front_job),
    .pop       (q_pop),
    .head_job  (head_job),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Back: sine/cosine lookups and the products for position and normal.
  uvs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .radius     (cfg_r.radius),
    .head_job   (head_job),
    .head_valid (q_not_empty),
    .head_pop   (q_pop),
    .vtx        (vtx),
    .vtx_valid  (out_tvalid),
    .vtx_ready  (out_tready)
  );

  assign out_tdata = {3'b000, vtx.tex_t, vtx.tex_s, vtx.norm_z, vtx.norm_y, vtx.norm_x,
                      vtx.pos_z, vtx.pos_y, vtx.pos_x};
  assign out_tuser = {vtx.prim_first, vtx.prim_kind};
  assign out_tlast = vtx.mesh_last;

endmodule

@@ design/uvs_front.sv @@
module uvs_front import uvs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic take,
  input  logic restart,
  output job_t job
);

  logic [7:0]  stack_r, stack_nxt, cur_stack;
  logic [8:0]  slice_r, slice_nxt, cur_slice;
  logic        pair_r, pair_nxt, cur_pair;
  logic        pole_r, pole_nxt, cur_pole;
  angle_t      phi_r, phi_nxt, cur_phi;
  angle_t      theta_r, theta_nxt, cur_theta;
  logic [16:0] s_r, s_nxt, cur_s;
  logic [16:0] t_r, t_nxt, cur_t;

  logic [8:0]  stacks, slices, last_stack;
  logic [16:0] t_dn, s_inc;
  logic [17:0] s_sum;
  angle_t      phi_inc;
  logic [7:0]  stack_inc;
  logic        slice_end, at_bottom, row_step, slice_step;

  // Restart acts as if the state were fresh from reset
  always_comb begin
    if (restart) begin
      cur_stack = '0;
      cur_slice = '0;
      cur_pair  = 1'b0;
      cur_pole  = 1'b1;
      cur_phi   = '0;
      cur_theta = '0;
      cur_s     = '0;
      cur_t     = ONE_Q16;
    end else begin
      cur_stack = stack_r;
      cur_slice = slice_r;
      cur_pair  = pair_r;
      cur_pole  = pole_r;
      cur_phi   = phi_r;
      cur_theta = theta_r;
      cur_s     = s_r;
      cur_t     = t_r;
    end
  end

  always_comb begin
    if (cfg.stack_count < 9'd2) stacks = 9'd2;
    else if (cfg.stack_count > 9'(MAX_DIVISIONS)) stacks = 9'(MAX_DIVISIONS);
    else stacks = cfg.stack_count;
    slices = (cfg.slice_count > 9'(MAX_DIVISIONS)) ? 9'(MAX_DIVISIONS) : cfg.slice_count;
  end

  assign last_stack = stacks - 9'd1;
  assign t_dn       = (cur_t > {1'b0, cfg.t_step}) ? (cur_t - {1'b0, cfg.t_step}) : 17'd0;
  assign phi_inc    = cur_phi + angle_t'(cfg.lat_step);
  assign stack_inc  = cur_stack + 8'd1;
  assign slice_end  = cur_slice >= slices;
  assign at_bottom  = {1'b0, cur_stack} >= last_stack;
  assign s_sum      = {1'b0, cur_s} + {1'b0, cfg.s_step};
  assign s_inc      = (s_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : s_sum[16:0];

  always_comb begin
    stack_nxt  = cur_stack;
    slice_nxt  = cur_slice;
    pair_nxt   = cur_pair;
    pole_nxt   = cur_pole;
    phi_nxt    = cur_phi;
    theta_nxt  = cur_theta;
    s_nxt      = cur_s;
    t_nxt      = cur_t;
    row_step   = 1'b0;
    slice_step = 1'b0;
    job        = '0;

    if (cur_pole) begin
      job.pole   = 1'b1;
      job.first  = 1'b1;
      job.bottom = cur_stack != 8'd0;
      job.s      = (cur_stack != 8'd0) ? 17'd0 : ONE_Q16;
      job.t      = 17'd0;
      pole_nxt   = 1'b0;
      slice_nxt  = '0;
      theta_nxt  = '0;
      s_nxt      = '0;
      pair_nxt   = 1'b0;
    end else if (cur_stack == 8'd0) begin
      // top ring
      job.phi   = phi_inc;
      job.theta = cur_theta;
      job.s     = cur_s;
      job.t     = t_dn;
      if (slice_end) row_step = 1'b1;
      else slice_step = 1'b1;
    end else if (at_bottom) begin
      // bottom ring, reversed walk
      job.phi   = cur_phi;
      job.theta = angle_t'(0) - cur_theta;
      job.s     = ONE_Q16 - cur_s;
      job.t     = cur_t;
      if (slice_end) begin
        job.last  = 1'b1;
        stack_nxt = '0;
        pole_nxt  = 1'b1;
        phi_nxt   = '0;
        t_nxt     = ONE_Q16;
        slice_nxt = '0;
        theta_nxt = '0;
        s_nxt     = '0;
        pair_nxt  = 1'b0;
      end else begin
        slice_step = 1'b1;
      end
    end else begin
      job.kind  = 1'b1;
      job.theta = cur_theta;
      job.s     = cur_s;
      if (!cur_pair) begin
        job.first = cur_slice == 9'd0;
        job.phi   = cur_phi;
        job.t     = cur_t;
        pair_nxt  = 1'b1;
      end else begin
        job.phi  = phi_inc;
        job.t    = t_dn;
        pair_nxt = 1'b0;
        if (slice_end) row_step = 1'b1;
        else slice_step = 1'b1;
      end
    end

    if (row_step) begin
      stack_nxt = stack_inc;
      phi_nxt   = phi_inc;
      t_nxt     = t_dn;
      slice_nxt = '0;
      theta_nxt = '0;
      s_nxt     = '0;
      pair_nxt  = 1'b0;
      pole_nxt  = {1'b0, stack_inc} >= last_stack;
    end
    if (slice_step) begin
      slice_nxt = cur_slice + 9'd1;
      theta_nxt = cur_theta + angle_t'(cfg.lon_step);
      s_nxt     = s_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_r <= '0;
      slice_r <= '0;
      pair_r  <= 1'b0;
      pole_r  <= 1'b1;
      phi_r   <= '0;
      theta_r <= '0;
      s_r     <= '0;
      t_r     <= ONE_Q16;
    end else if (take) begin
      stack_r <= stack_nxt;
      slice_r <= slice_nxt;
      pair_r  <= pair_nxt;
      pole_r  <= pole_nxt;
      phi_r   <= phi_nxt;
      theta_r <= theta_nxt;
      s_r     <= s_nxt;
      t_r     <= t_nxt;
    end
  end

endmodule

@@ design/uvs_queue.sv @@
module uvs_queue import uvs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic not_empty,
  output logic full
);

  job_t                slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;

  assign not_empty = count_r != '0;
  assign full      = count_r == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign head_job  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

@@ design/uvs_back.sv @@
module uvs_back import uvs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    [15:0] radius,
  input  job_t    head_job,
  input  logic    head_valid,
  output logic    head_pop,
  output vertex_t vtx,
  output logic    vtx_valid,
  input  logic    vtx_ready
);

  localparam sine_rom_t PHI_ROM   = build_sine_rom();
  localparam sine_rom_t THETA_ROM = build_sine_rom();

  typedef struct packed {
    logic sp;
    logic cp;
    logic st;
    logic ct;
  } sign_t;

  logic      adv;
  rom_addr_t sp_a, cp_a, st_a, ct_a;

  // stage A: table reads
  logic        a_valid_r;
  logic [15:0] a_sp_r, a_cp_r, a_st_r, a_ct_r;
  sign_t       a_neg_r;
  job_t        a_job_r;

  // stage B: first products
  logic        b_valid_r;
  logic [15:0] b_rs_r, b_z_r, b_nx_r, b_ny_r, b_st_r, b_ct_r, b_cp_r;
  sign_t       b_neg_r;
  job_t        b_job_r;

  logic        out_valid_r;
  vertex_t     out_r, out_nxt;
  logic [15:0] x_mag, y_mag;

  // whole pipe moves together; output register is the only holding point
  assign adv       = !out_valid_r || vtx_ready;
  assign head_pop  = adv && head_valid;
  assign vtx       = out_r;
  assign vtx_valid = out_valid_r;

  assign sp_a = sine_addr(head_job.phi);
  assign cp_a = cos_addr(head_job.phi);
  assign st_a = sine_addr(head_job.theta);
  assign ct_a = cos_addr(head_job.theta);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sp_r  <= PHI_ROM[sp_a.idx];
      a_cp_r  <= PHI_ROM[cp_a.idx];
      a_st_r  <= THETA_ROM[st_a.idx];
      a_ct_r  <= THETA_ROM[ct_a.idx];
      a_neg_r <= '{sp: sp_a.neg, cp: cp_a.neg, st: st_a.neg, ct: ct_a.neg};
      a_job_r <= head_job;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_rs_r  <= mul_round(radius, a_sp_r);
      b_z_r   <= mul_round(radius, a_cp_r);
      b_nx_r  <= mul_round(a_sp_r, a_ct_r);
      b_ny_r  <= mul_round(a_sp_r, a_st_r);
      b_st_r  <= a_st_r;
      b_ct_r  <= a_ct_r;
      b_cp_r  <= a_cp_r;
      b_neg_r <= a_neg_r;
      b_job_r <= a_job_r;
    end
  end

  assign x_mag = mul_round(b_rs_r, b_ct_r);
  assign y_mag = mul_round(b_rs_r, b_st_r);

  always_comb begin
    out_nxt.tex_s      = b_job_r.s;
    out_nxt.tex_t      = b_job_r.t;
    out_nxt.prim_kind  = b_job_r.kind;
    out_nxt.prim_first = b_job_r.first;
    out_nxt.mesh_last  = b_job_r.last;
    if (b_job_r.pole) begin
      out_nxt.pos_x  = '0;
      out_nxt.pos_y  = '0;
      out_nxt.pos_z  = to_s17(radius, b_job_r.bottom);
      out_nxt.norm_x = '0;
      out_nxt.norm_y = '0;
      out_nxt.norm_z = b_job_r.bottom ? NORM_NEG_DN : NORM_POS_UP;
    end else begin
      out_nxt.pos_x  = to_s17(x_mag, b_neg_r.sp ^ b_neg_r.ct);
      out_nxt.pos_y  = to_s17(y_mag, b_neg_r.sp ^ b_neg_r.st);
      out_nxt.pos_z  = to_s17(b_z_r, b_neg_r.cp);
      out_nxt.norm_x = norm_sat(b_nx_r, b_neg_r.sp ^ b_neg_r.ct);
      out_nxt.norm_y = norm_sat(b_ny_r, b_neg_r.sp ^ b_neg_r.st);
      out_nxt.norm_z = norm_sat(b_cp_r, b_neg_r.cp);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= head_pop;
      b_valid_r   <= a_valid_r;
      out_valid_r <= b_valid_r;
    end
  end

endmodule

@@ design/uvs_checker.sv @@
module uvs_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);

  // stalled vertex holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("vertex changed while stalled");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // last vertex of the mesh belongs to the bottom fan
  a_last_fan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tuser[0] && !out_tuser[1])
    else $error("mesh end outside bottom fan");

  // a fan opens only at a pole: normal lies on the axis
  a_pole: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] && out_tuser[1] |->
      out_tdata[66:51] == 16'd0 && out_tdata[82:67] == 16'd0 &&
      out_tdata[16:0] == 17'd0 && out_tdata[33:17] == 17'd0)
    else $error("fan start off the pole");

  // texcoords never exceed one
  a_tex: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[115:99] <= 17'h10000 && out_tdata[132:116] <= 17'h10000)
    else $error("texcoord above one");

endmodule

bind uv_sphere_vertex_generator_top uvs_checker u_uvs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

@@ dv/uv_sphere_vertex_generator_top_tb.sv @@
module uv_sphere_vertex_generator_top_tb;
  import uvs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run shape
  localparam int NUM_PHASES       = 8;
  localparam int ITEMS_PER_PHASE  = 88;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES      = 16;
  localparam int CYCLE_LIMIT      = 400000;

  typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

  // One line of the directed script: either a register write or one item
  typedef struct packed {
    row_kind_t   kind;
    cfg_reg_t    sel;
    logic [16:0] value;
    logic        restart;
    logic        typed;     // want holds a hand-written vertex
    vertex_t     want;
  } script_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;    // [0] restart, [7:1] zero
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;        // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t
  logic [1:0]   out_tuser;        // [0] prim_kind, [1] prim_first
  logic         out_tlast;        // mesh_last
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [16:0]  cfg_data = '0;

  uv_sphere_vertex_generator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Mesh walker: shadow registers, sequencer state, sine table
  // ---------------------------------------------------------------------------
  logic [8:0]  stacks_reg = RST_STACK_COUNT;
  logic [8:0]  slices_reg = RST_SLICE_COUNT;
  logic [15:0] radius_reg = RST_RADIUS;
  angle_t      phi_inc    = RST_LAT_STEP;
  angle_t      theta_inc  = RST_LON_STEP;
  logic [16:0] s_inc      = RST_S_STEP;
  logic [15:0] t_inc      = RST_T_STEP;

  logic [7:0]  row_idx;     // latitude band being walked
  logic [8:0]  col_idx;     // slice within the band
  logic        strip_lo;    // 1 when the lower vertex of a strip pair is next
  logic        pole_due;    // a pole comes next (bottom one if row_idx != 0)
  angle_t      phi_acc;
  angle_t      theta_acc;
  logic [16:0] s_acc;
  logic [16:0] t_acc;

  int sine_q15 [0:SINE_TABLE_DEPTH];

  vertex_t     pending_vertices [$];
  script_row_t directed_rows [$];

  int   mismatches = 0;
  int   cycles = 0;
  logic idle_on = 1'b1;
  logic long_hold_req = 1'b0;

  function automatic longint lut_sin(input angle_t a);
    int idx;
    idx = (int'(a[ANGLE_BITS-3:0]) * SINE_TABLE_DEPTH + QUARTER_TURN / 2) / QUARTER_TURN;
    if (idx > SINE_TABLE_DEPTH) idx = SINE_TABLE_DEPTH;
    if (a[ANGLE_BITS-2]) idx = SINE_TABLE_DEPTH - idx;
    return a[ANGLE_BITS-1] ? -longint'(sine_q15[idx]) : longint'(sine_q15[idx]);
  endfunction

  // Q1.15 product, round half away from zero
  function automatic longint qmul(input longint a, input longint b);
    longint p;
    longint m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = (m + 16384) >>> 15;
    return (p < 0) ? -m : m;
  endfunction

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic [16:0] t_lower(input logic [16:0] t);
    return (t > t_inc) ? t - t_inc : 17'd0;
  endfunction

  function automatic vertex_t surface_point(input angle_t phi, input angle_t th,
                                            input logic [16:0] s, input logic [16:0] t);
    vertex_t v;
    longint  sp;
    longint  cp;
    longint  st;
    longint  ct;
    longint  rs;
    sp = lut_sin(phi);
    cp = lut_sin(angle_t'(phi + QUARTER_TURN));
    st = lut_sin(th);
    ct = lut_sin(angle_t'(th + QUARTER_TURN));
    rs = qmul(longint'(radius_reg), sp);
    v = '0;
    v.pos_x  = 17'(qmul(rs, ct));
    v.pos_y  = 17'(qmul(rs, st));
    v.pos_z  = 17'(qmul(longint'(radius_reg), cp));
    v.norm_x = 16'(clip16(qmul(sp, ct)));
    v.norm_y = 16'(clip16(qmul(sp, st)));
    v.norm_z = 16'(clip16(cp));
    v.tex_s  = s;
    v.tex_t  = t;
    return v;
  endfunction

  function automatic void rewind_row();
    col_idx   = '0;
    theta_acc = '0;
    s_acc     = '0;
    strip_lo  = 1'b0;
  endfunction

  function automatic void rewind_mesh();
    row_idx  = '0;
    pole_due = 1'b1;
    phi_acc  = '0;
    t_acc    = ONE_Q16;
    rewind_row();
  endfunction

  function automatic void step_row(input int stacks);
    row_idx = row_idx + 8'd1;
    phi_acc = phi_acc + phi_inc;
    t_acc   = t_lower(t_acc);
    rewind_row();
    if (row_idx >= stacks - 1) pole_due = 1'b1;
  endfunction

  function automatic void step_col();
    logic [17:0] s;
    s = s_acc + s_inc;
    col_idx   = col_idx + 9'd1;
    theta_acc = theta_acc + theta_inc;
    s_acc     = (s > ONE_Q16) ? ONE_Q16 : s[16:0];
  endfunction

  // Vertex emitted for one accepted item; advances the walker
  function automatic vertex_t advance_mesh(input logic restart);
    vertex_t v;
    int      stacks;
    int      slices;
    logic    kind;
    logic    first;
    logic    last;
    stacks = (stacks_reg < 2) ? 2 :
             (stacks_reg > MAX_DIVISIONS) ? MAX_DIVISIONS : int'(stacks_reg);
    slices = (slices_reg > MAX_DIVISIONS) ? MAX_DIVISIONS : int'(slices_reg);
    kind  = 1'b0;
    first = 1'b0;
    last  = 1'b0;
    if (restart) rewind_mesh();
    if (pole_due) begin
      first = 1'b1;
      v = '0;
      if (row_idx == 0) begin
        v.pos_z  = {1'b0, radius_reg};
        v.norm_z = NORM_POS_UP;
        v.tex_s  = ONE_Q16;
      end else begin
        v.pos_z  = 17'd0 - {1'b0, radius_reg};
        v.norm_z = NORM_NEG_DN;
      end
      pole_due = 1'b0;
      rewind_row();
    end else if (row_idx == 0) begin
      // top ring sits one step below the pole
      v = surface_point(phi_acc + phi_inc, theta_acc, s_acc, t_lower(t_acc));
      if (col_idx >= slices) step_row(stacks);
      else step_col();
    end else if (row_idx >= stacks - 1) begin
      // bottom ring: longitude negated, s mirrored
      v = surface_point(phi_acc, angle_t'(0) - theta_acc, ONE_Q16 - s_acc, t_acc);
      if (col_idx >= slices) begin
        last = 1'b1;
        rewind_mesh();
      end else begin
        step_col();
      end
    end else begin
      kind = 1'b1;
      if (!strip_lo) begin
        first = (col_idx == 0);
        v = surface_point(phi_acc, theta_acc, s_acc, t_acc);
        strip_lo = 1'b1;
      end else begin
        v = surface_point(phi_acc + phi_inc, theta_acc, s_acc, t_lower(t_acc));
        strip_lo = 1'b0;
        if (col_idx >= slices) step_row(stacks);
        else step_col();
      end
    end
    v.prim_kind  = kind;
    v.prim_first = first;
    v.mesh_last  = last;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed script rows
  // ---------------------------------------------------------------------------
  function automatic script_row_t reg_row(input cfg_reg_t sel, input logic [16:0] value);
    script_row_t r;
    r = '0;
    r.kind  = ROW_WRITE;
    r.sel   = sel;
    r.value = value;
    return r;
  endfunction

  function automatic script_row_t item_row(input logic restart);
    script_row_t r;
    r = '0;
    r.kind    = ROW_ITEM;
    r.restart = restart;
    return r;
  endfunction

  // Pole with hand-written z, normal z and s, and prim_first set; everything else zero
  function automatic script_row_t pole_row(input logic restart, input logic [16:0] z,
                                           input logic [15:0] nz, input logic [16:0] s);
    script_row_t r;
    r = item_row(restart);
    r.typed = 1'b1;
    r.want.pos_z      = z;
    r.want.norm_z     = nz;
    r.want.tex_s      = s;
    r.want.prim_first = 1'b1;
    return r;
  endfunction

  function automatic void add_row(input script_row_t r);
    directed_rows = {directed_rows, r};
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Leaves cfg_valid high; caller drops it after the last write of a batch
  task automatic write_reg(input cfg_reg_t sel, input logic [16:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (sel)
      REG_STACK_COUNT: stacks_reg = value[8:0];
      REG_SLICE_COUNT: slices_reg = value[8:0];
      REG_RADIUS:      radius_reg = value[15:0];
      REG_LAT_STEP:    phi_inc    = value[15:0];
      REG_LON_STEP:    theta_inc  = value[15:0];
      REG_S_STEP:      s_inc      = value;
      REG_T_STEP:      t_inc      = value[15:0];
      default: ;
    endcase
  endtask

  task automatic offer_item(input logic restart, input logic typed, input vertex_t want);
    vertex_t guess;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, restart};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    guess = advance_mesh(restart);
    if (typed) guess = want;
    pending_vertices = {pending_vertices, guess};
  endtask

  // Block is idle once every vertex owed has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off to back up the queue
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every accepted vertex against the oldest one owed
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    vertex_t seen;
    vertex_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.pos_x      = out_tdata[16:0];
      seen.pos_y      = out_tdata[33:17];
      seen.pos_z      = out_tdata[50:34];
      seen.norm_x     = out_tdata[66:51];
      seen.norm_y     = out_tdata[82:67];
      seen.norm_z     = out_tdata[98:83];
      seen.tex_s      = out_tdata[115:99];
      seen.tex_t      = out_tdata[132:116];
      seen.prim_kind  = out_tuser[0];
      seen.prim_first = out_tuser[1];
      seen.mesh_last  = out_tlast;
      if (pending_vertices.size() == 0) begin
        $error("vertex out with none owed: tdata 0x%0h", out_tdata);
        mismatches++;
      end else begin
        want = pending_vertices.pop_front();
        check_field("pos_x", want.pos_x, seen.pos_x);
        check_field("pos_y", want.pos_y, seen.pos_y);
        check_field("pos_z", want.pos_z, seen.pos_z);
        check_field("norm_x", want.norm_x, seen.norm_x);
        check_field("norm_y", want.norm_y, seen.norm_y);
        check_field("norm_z", want.norm_z, seen.norm_z);
        check_field("tex_s", want.tex_s, seen.tex_s);
        check_field("tex_t", want.tex_t, seen.tex_t);
        check_field("prim_kind", want.prim_kind, seen.prim_kind);
        check_field("prim_first", want.prim_first, seen.prim_first);
        check_field("mesh_last", want.mesh_last, seen.mesh_last);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL uv_sphere_vertex_generator_top");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] series;
    logic        reg_open;
    logic [16:0] stk;
    logic [16:0] slc;
    logic [16:0] rad;
    logic [16:0] phi;
    logic [16:0] th;
    logic [16:0] ss;
    logic [16:0] ts;
    script_row_t row;

    // Quarter-wave sine, Q2.30 Taylor series to x^15, rounded to Q1.15
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x      = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      x2     = (x * x) >> 30;
      term   = x;
      series = x;
      for (int n = 3; n <= 15; n += 2) begin
        term = ((term * x2) >> 30) / 64'((n - 1) * n);
        if (((n >> 1) & 1) != 0) series = series - term;
        else series = series + term;
      end
      sine_q15[k] = int'((series + 64'd16384) >> 15);
    end
    rewind_mesh();

    // Default registers: top pole, a couple of ring vertices, restart
    add_row(pole_row(1'b0, 17'd256, NORM_POS_UP, ONE_Q16));
    add_row(item_row(1'b0));
    add_row(item_row(1'b0));
    add_row(pole_row(1'b1, 17'd256, NORM_POS_UP, ONE_Q16));
    // Smallest mesh at the largest steps and radius: pole, 1-vertex ring, pole, ring
    add_row(reg_row(REG_STACK_COUNT, 17'd2));
    add_row(reg_row(REG_SLICE_COUNT, 17'd0));
    add_row(reg_row(REG_RADIUS, 17'd65535));
    add_row(reg_row(REG_LAT_STEP, 17'd32768));
    add_row(reg_row(REG_LON_STEP, 17'd65535));
    add_row(reg_row(REG_S_STEP, 17'd65536));
    add_row(reg_row(REG_T_STEP, 17'd32768));
    add_row(pole_row(1'b1, 17'h0FFFF, NORM_POS_UP, ONE_Q16));
    add_row(item_row(1'b0));
    add_row(pole_row(1'b0, 17'h10001, NORM_NEG_DN, 17'd0)); // -65535
    add_row(item_row(1'b0));                                 // mesh end
    add_row(pole_row(1'b0, 17'h0FFFF, NORM_POS_UP, ONE_Q16)); // wrap
    // Counts below range and above range, zero radius and zero steps
    add_row(reg_row(REG_STACK_COUNT, 17'd0));
    add_row(reg_row(REG_SLICE_COUNT, 17'd511));
    add_row(reg_row(REG_RADIUS, 17'd0));
    add_row(reg_row(REG_LAT_STEP, 17'd0));
    add_row(reg_row(REG_LON_STEP, 17'd0));
    add_row(reg_row(REG_S_STEP, 17'd0));
    add_row(reg_row(REG_T_STEP, 17'd0));
    add_row(pole_row(1'b1, 17'd0, NORM_POS_UP, ONE_Q16));
    add_row(item_row(1'b0));
    add_row(item_row(1'b0));
    // Texcoord saturation: s clips at one on the ring
    add_row(reg_row(REG_STACK_COUNT, 17'd300));
    add_row(reg_row(REG_SLICE_COUNT, 17'd3));
    add_row(reg_row(REG_RADIUS, 17'd256));
    add_row(reg_row(REG_LAT_STEP, 17'd1000));
    add_row(reg_row(REG_LON_STEP, 17'd20000));
    add_row(reg_row(REG_S_STEP, 17'd40000));
    add_row(reg_row(REG_T_STEP, 17'd30000));
    add_row(pole_row(1'b1, 17'd256, NORM_POS_UP, ONE_Q16));
    for (int k = 0; k < 7; k++) add_row(item_row(1'b0));
    // Shrink the stack count mid-mesh, no restart
    add_row(reg_row(REG_STACK_COUNT, 17'd3));
    for (int k = 0; k < 4; k++) add_row(item_row(1'b0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    reg_open = 1'b0;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        if (!reg_open) drain();
        write_reg(row.sel, row.value);
        reg_open = 1'b1;
      end else begin
        if (reg_open) cfg_valid <= 1'b0;
        reg_open = 1'b0;
        offer_item(row.restart, row.typed, row.want);
      end
    end

    // Random phases: fresh registers each time, mostly small meshes walked
    // end to end, with rare restarts; state carries over between phases
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      stk = ($urandom_range(0, 4) == 0) ? 17'($urandom_range(0, 511)) :
                                          17'($urandom_range(2, 6));
      slc = ($urandom_range(0, 4) == 0) ? 17'($urandom_range(0, 511)) :
                                          17'($urandom_range(0, 6));
      case ($urandom_range(0, 3))
        0: rad = 17'd0;
        1: rad = 17'd65535;
        default: rad = 17'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 3))
        0: phi = 17'd0;
        1: phi = 17'd32768;
        default: phi = 17'($urandom_range(0, 32768));
      endcase
      th = ($urandom_range(0, 3) == 0) ? 17'd65535 : 17'($urandom_range(0, 65535));
      case ($urandom_range(0, 3))
        0: ss = 17'd0;
        1: ss = 17'd65536;
        default: ss = 17'($urandom_range(0, 65536));
      endcase
      case ($urandom_range(0, 3))
        0: ts = 17'd0;
        1: ts = 17'd32768;
        default: ts = 17'($urandom_range(0, 32768));
      endcase
      write_reg(REG_STACK_COUNT, stk);
      write_reg(REG_SLICE_COUNT, slc);
      write_reg(REG_RADIUS, rad);
      write_reg(REG_LAT_STEP, phi);
      write_reg(REG_LON_STEP, th);
      write_reg(REG_S_STEP, ss);
      write_reg(REG_T_STEP, ts);
      cfg_valid <= 1'b0;

      // phase 1 backs up the block behind a long output hold; last phase runs flat out
      idle_on = (phase != 1) && (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      if (phase == 1) long_hold_req = 1'b1;

      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k == 0) offer_item(1'($urandom_range(0, 1)), 1'b0, '0);
        else offer_item(($urandom_range(0, 39) == 0), 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_vertices.size() == 0) begin
      $display("PASS uv_sphere_vertex_generator_top");
    end else begin
      $display("FAIL uv_sphere_vertex_generator_top");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/uvs_pkg.sv
design/uvs_front.sv
design/uvs_queue.sv
design/uvs_back.sv
design/uv_sphere_vertex_generator_top.sv
design/uvs_checker.sv
dv/uv_sphere_vertex_generator_top_tb.sv
